// File: rtl/stg_pkg.sv
// ---------------------------------------------------------------------------
// Sine tone generator package
// Shared field widths, command codes, reset values and output queue sizing.
// ---------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

    localparam int CMD_W      = 1;
    localparam int TUNE_W     = 31;
    localparam int DUR_IN_W   = 20;
    localparam int AMP_W      = 15;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * AMP_W;
    localparam int FRAC_SHIFT = 15;

    localparam logic [AMP_W-1:0] AMP_RESET = 15'd28000;

    localparam real PI       = 3.14159265358979323846;
    localparam real SINE_PEAK = 32767.0;

    // Output queue: it has room for every tick item that is in flight.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

// File: rtl/sine_tone_generator_core.sv
// ---------------------------------------------------------------------------
// Sine tone generator core
// Phase accumulator tone synthesis with a quarter-wave sine ROM and an
// amplitude multiplier, one sample per tick transfer.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries a command. A start transfer
// loads the tuning word and the tone length, clears the phase and produces
// no output. A tick transfer produces exactly one sample on the output
// channel (out_valid/out_ready): a scaled sine value while the tone lasts,
// zero afterwards.
// The amplitude register is written through cfg_valid/cfg_ready; it is
// always ready and must only be written while no ticks are in flight.
// A tick's sample reaches the output through the ROM read, the multiply and
// the output queue write. Throughput is one item per cycle while in_ready is
// high, set by the phase and counter update on each accepted tick.
// The output queue holds four samples; in_ready drops only when the queue
// plus the two pipeline stages hold four samples, so a stalled receiver holds
// the input off after at most four outstanding ticks.
// Reset clears phase, tuning word and remaining count (silent) and loads
// the default amplitude.
// ---------------------------------------------------------------------------
`default_nettype none

module sine_tone_generator_core #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int DURATION_BITS   = 20
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [stg_pkg::CMD_W-1:0]          cmd,
    input  wire logic [stg_pkg::TUNE_W-1:0]         tuning_word,
    input  wire logic [stg_pkg::DUR_IN_W-1:0]       duration_samples,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [stg_pkg::AMP_W-1:0]          amplitude,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [stg_pkg::SAMPLE_W-1:0]     sample
);

    localparam int ROM_IDX_W = TABLE_ADDR_BITS - 1;
    localparam int QUAD_W    = TABLE_ADDR_BITS - 2;
    localparam int QUARTER   = 1 << QUAD_W;
    localparam int SUM_W     = (PHASE_BITS > stg_pkg::TUNE_W) ? PHASE_BITS : stg_pkg::TUNE_W;
    localparam int CMP_W     = (DURATION_BITS > stg_pkg::DUR_IN_W) ?
                               DURATION_BITS : stg_pkg::DUR_IN_W;
    localparam logic [DURATION_BITS-1:0] DUR_MAX = {DURATION_BITS{1'b1}};
    localparam real ANG_STEP = stg_pkg::PI / (2.0 * QUARTER);

    typedef logic [stg_pkg::AMP_W-1:0] rom_t [0:QUARTER];

    // Quarter-wave table: round(32767*sin(pi/2*m/QUARTER)), halves away from zero.
    function automatic rom_t build_rom();
        rom_t rom;
        real  ang;
        real  val;
        for (int m = 0; m <= QUARTER; m++) begin
            ang    = ANG_STEP * m;
            val    = stg_pkg::SINE_PEAK * $sin(ang) + 0.5;
            rom[m] = stg_pkg::AMP_W'($rtoi(val));
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Tone state
    logic [PHASE_BITS-1:0]          phase_reg, phase_next;
    logic [DURATION_BITS-1:0]       remain_reg, remain_next;
    logic [stg_pkg::TUNE_W-1:0]     tune_reg, tune_next;
    logic [stg_pkg::AMP_W-1:0]      amp_reg;

    // Pipeline stage 1: ROM read
    logic                           v1_reg;
    logic                           act1_reg;
    logic                           neg1_reg;
    logic [stg_pkg::AMP_W-1:0]      rom_q_reg;

    // Pipeline stage 2: product
    logic                           v2_reg;
    logic                           act2_reg;
    logic                           neg2_reg;
    logic [stg_pkg::PROD_W-1:0]     prod_reg;

    // Output queue
    logic [stg_pkg::SAMPLE_W-1:0]   queue_mem_reg [stg_pkg::QUEUE_DEPTH];
    logic [stg_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [stg_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [stg_pkg::QCNT_W-1:0]     count_reg;
    logic [stg_pkg::QCNT_W-1:0]     inflight;

    logic                           in_xfer;
    logic                           is_start;
    logic                           is_tick;
    logic                           active;
    logic [TABLE_ADDR_BITS-1:0]     tab_addr;
    logic [ROM_IDX_W-1:0]           rom_idx;
    logic [SUM_W-1:0]               phase_sum;
    logic [CMP_W-1:0]               dur_wide;
    logic [DURATION_BITS-1:0]       dur_load;
    logic [stg_pkg::AMP_W-1:0]      mag;
    logic [stg_pkg::SAMPLE_W-1:0]   result;
    logic                           out_xfer;

    assign inflight = count_reg + stg_pkg::QCNT_W'(v1_reg) + stg_pkg::QCNT_W'(v2_reg);
    assign in_ready = (inflight < stg_pkg::QCNT_W'(stg_pkg::QUEUE_DEPTH));
    assign cfg_ready = 1'b1;

    assign in_xfer  = in_valid && in_ready;
    assign is_start = (cmd == stg_pkg::CMD_START);
    assign is_tick  = in_xfer && !is_start;
    assign active   = (remain_reg != '0);

    // Fold the full-wave address onto the quarter table; the top bit gives the sign.
    assign tab_addr = phase_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    always_comb
    begin
        if (tab_addr[QUAD_W])
        begin
            rom_idx = ROM_IDX_W'(QUARTER) - ROM_IDX_W'(tab_addr[QUAD_W-1:0]);
        end
        else
        begin
            rom_idx = ROM_IDX_W'(tab_addr[QUAD_W-1:0]);
        end
    end

    assign phase_sum = SUM_W'(phase_reg) + SUM_W'(tune_reg);
    assign dur_wide  = CMP_W'(duration_samples);
    assign dur_load  = (dur_wide > CMP_W'(DUR_MAX)) ? DUR_MAX : DURATION_BITS'(dur_wide);

    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        tune_next   = tune_reg;
        if (in_xfer)
        begin
            if (is_start)
            begin
                phase_next  = '0;
                remain_next = dur_load;
                tune_next   = tuning_word;
            end
            else if (active)
            begin
                phase_next  = phase_sum[PHASE_BITS-1:0];
                remain_next = remain_reg - DURATION_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            remain_reg <= '0;
            tune_reg   <= '0;
            amp_reg    <= stg_pkg::AMP_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            tune_reg   <= tune_next;
            if (cfg_valid && cfg_ready)
            begin
                amp_reg <= amplitude;
            end
        end
    end

    // Synchronous ROM read, then the product stage
    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[rom_idx];
        act1_reg  <= active;
        neg1_reg  <= tab_addr[TABLE_ADDR_BITS-1];
        prod_reg  <= stg_pkg::PROD_W'(rom_q_reg) * stg_pkg::PROD_W'(amp_reg);
        act2_reg  <= act1_reg;
        neg2_reg  <= neg1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= is_tick;
            v2_reg <= v1_reg;
        end
    end

    // The magnitude is shifted before the sign goes on, so the result truncates toward zero.
    assign mag = prod_reg[stg_pkg::FRAC_SHIFT +: stg_pkg::AMP_W];
    always_comb
    begin
        if (!act2_reg)
        begin
            result = '0;
        end
        else if (neg2_reg)
        begin
            result = stg_pkg::SAMPLE_W'(0) - stg_pkg::SAMPLE_W'(mag);
        end
        else
        begin
            result = stg_pkg::SAMPLE_W'(mag);
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_xfer  = out_valid && out_ready;
    assign sample    = queue_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            queue_mem_reg[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (v2_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + stg_pkg::QPTR_W'(1);
            end
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + stg_pkg::QPTR_W'(1);
            end
            count_reg <= count_reg + stg_pkg::QCNT_W'(v2_reg) - stg_pkg::QCNT_W'(out_xfer);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        inflight <= stg_pkg::QCNT_W'(stg_pkg::QUEUE_DEPTH))
        else $error("output queue plus pipeline exceeds queue depth");

    a_start_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && is_start) |=> (phase_reg == '0))
        else $error("start transfer did not clear the phase");

    a_tick_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (is_tick && active) |=> (remain_reg == $past(remain_reg) - DURATION_BITS'(1)))
        else $error("tick during a tone did not decrement the remaining count");

    a_tick_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        is_tick |=> ##1 v2_reg)
        else $error("accepted tick did not reach the product stage");
`endif

endmodule

`default_nettype wire
